### src/lcdseq_pkg.sv
// Package for the LCD nibble sequencer: payload structs, job descriptor,
// command codes, expander bit positions and the init byte table. No dependencies.
package lcdseq_pkg;

    localparam int RS_BIT_POS = 0;
    localparam int RW_BIT_POS = 1;
    localparam int EN_BIT_POS = 2;
    localparam int BL_BIT_POS = 3;

    localparam logic [2:0] KIND_PUT   = 3'd0;
    localparam logic [2:0] KIND_SETPOS = 3'd1;
    localparam logic [2:0] KIND_CLEAR = 3'd2;
    localparam logic [2:0] KIND_HOME  = 3'd3;
    localparam logic [2:0] KIND_INIT  = 3'd4;

    localparam logic [7:0] CHAR_CR = 8'h0d;
    localparam logic [7:0] CHAR_LF = 8'h0a;

    localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
    localparam logic [7:0] CMD_CLEAR     = 8'h01;
    localparam logic [7:0] CMD_HOME      = 8'h02;

    // Config register indexes.
    localparam logic [1:0] REG_COLUMNS   = 2'd0;
    localparam logic [1:0] REG_ROWS      = 2'd1;
    localparam logic [1:0] REG_BACKLIGHT = 2'd2;

    localparam logic [4:0] INIT_WRITES = 5'd24;
    localparam logic [4:0] INIT_NIBBLE_WRITES = 5'd8;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] character;
        logic [5:0] target_column;
        logic [1:0] target_row;
    } t_cmd;

    typedef struct packed {
        logic [7:0] expander_byte;
        logic [2:0] hold_ms;
        logic       last_write;
    } t_wr;

    // One queued job: one or two LCD bytes, or the init burst.
    // The second byte is always a set-position command (RS low, one extra ms).
    typedef struct packed {
        logic       init;
        logic       two;
        logic [7:0] b0;
        logic       rs0;
        logic [1:0] x0;
        logic [7:0] b1;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [7:0] row_base(input logic [1:0] row);
        case (row)
            2'd0:    row_base = 8'h00;
            2'd1:    row_base = 8'h40;
            2'd2:    row_base = 8'h14;
            default: row_base = 8'h54;
        endcase
    endfunction

    function automatic logic [7:0] init_byte(input logic [1:0] k);
        case (k)
            2'd0:    init_byte = 8'h2c;
            2'd1:    init_byte = 8'h0d;
            2'd2:    init_byte = 8'h06;
            default: init_byte = 8'h01;
        endcase
    endfunction

endpackage

### src/lcdseq_front.sv
// Front end of the LCD sequencer: accepts commands, tracks the cursor and
// turns each command into a job descriptor. Depends on lcdseq_pkg.
module lcdseq_front import lcdseq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  t_cmd       i_cmd,
    input  logic [5:0] i_columns,
    input  logic [2:0] i_rows,
    output logic       o_job_push,
    output t_job       o_job
);

    logic [5:0] r_col, n_col;
    logic [1:0] r_row, n_row;
    logic [2:0] next_row_full;
    logic [1:0] next_row;
    logic [6:0] nx;
    logic       job_valid;

    // (row + 1) mod effective row count, rows clamped to 1..4
    always_comb begin
        next_row_full = {1'b0, r_row} + 3'd1;
        case (i_rows)
            3'd0, 3'd1: next_row = 2'd0;
            3'd2:       next_row = {1'b0, next_row_full[0]};
            3'd3:       next_row = (next_row_full >= 3'd3) ? 2'(next_row_full - 3'd3)
                                                           : next_row_full[1:0];
            default:    next_row = (next_row_full == 3'd4) ? 2'd0 : next_row_full[1:0];
        endcase
    end

    always_comb begin
        n_col     = r_col;
        n_row     = r_row;
        job_valid = 1'b0;
        o_job     = '0;
        nx        = {1'b0, r_col} + 7'd1;
        unique case (i_cmd.kind)
            KIND_PUT: begin
                if (i_cmd.character == CHAR_CR) begin
                    n_col = 6'd0;
                end else if (i_cmd.character == CHAR_LF) begin
                    job_valid = 1'b1;
                    o_job.b0  = CMD_SET_DDRAM + row_base(next_row);
                    o_job.x0  = 2'd1;
                    n_col     = 6'd0;
                    n_row     = next_row;
                end else begin
                    job_valid = 1'b1;
                    o_job.b0  = i_cmd.character;
                    o_job.rs0 = 1'b1;
                    o_job.x0  = 2'd1;
                    n_col     = nx[5:0];
                    // wrap to the start of the next line
                    if (nx >= {1'b0, i_columns}) begin
                        o_job.two = 1'b1;
                        o_job.b1  = CMD_SET_DDRAM + row_base(next_row);
                        n_col     = 6'd0;
                        n_row     = next_row;
                    end
                end
            end
            KIND_SETPOS: begin
                job_valid = 1'b1;
                o_job.b0  = CMD_SET_DDRAM + row_base(i_cmd.target_row)
                          + {2'b00, i_cmd.target_column};
                o_job.x0  = 2'd1;
                n_col     = i_cmd.target_column;
                n_row     = i_cmd.target_row;
            end
            KIND_CLEAR, KIND_HOME: begin
                job_valid = 1'b1;
                o_job.b0  = (i_cmd.kind == KIND_CLEAR) ? CMD_CLEAR : CMD_HOME;
                o_job.x0  = 2'd2;
                n_col     = 6'd0;
                n_row     = 2'd0;
            end
            KIND_INIT: begin
                job_valid  = 1'b1;
                o_job.init = 1'b1;
                n_col      = 6'd0;
                n_row      = 2'd0;
            end
            default: begin
            end
        endcase
    end

    assign o_job_push = i_accept && job_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= 6'd0;
            r_row <= 2'd0;
        end else if (i_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

### src/lcdseq_jobq.sv
// Two-entry job queue between the front end and the write sequencer.
// Depends on lcdseq_pkg.
module lcdseq_jobq import lcdseq_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    input  logic    i_pop,
    output t_job    o_job,
    output t_q_stat o_stat
);

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       do_push, do_pop;

    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);
    assign o_job        = r_mem[r_rp];
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wp <= ~r_wp;
            if (do_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule

### src/lcdseq_back.sv
// Write sequencer: expands the head job into expander writes, one per cycle when
// the result register is free or popped, into that register. Depends on lcdseq_pkg.
module lcdseq_back import lcdseq_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_job    i_job,
    input  t_q_stat i_qstat,
    input  logic    i_backlight,
    input  logic    i_pop,
    output logic    o_job_pop,
    output t_wr     o_wr,
    output logic    o_valid
);

    logic [4:0] r_idx;
    logic       r_valid;
    t_wr        r_wr;
    t_wr        wr;
    logic       slot_free, emit;
    logic [7:0] lbyte;
    logic [4:0] j;
    logic [3:0] nib;
    logic       rs, en;
    logic [1:0] ext;
    logic       low_end;

    assign slot_free = !r_valid || i_pop;
    assign emit      = slot_free && !i_qstat.empty;
    assign en        = ~r_idx[0];
    assign low_end   = r_idx[1] & r_idx[0];
    assign j         = r_idx - INIT_NIBBLE_WRITES;

    always_comb begin
        lbyte = i_job.b0;
        rs    = 1'b0;
        ext   = 2'd0;
        nib   = 4'h0;
        wr    = '0;
        if (i_job.init) begin
            if (r_idx < INIT_NIBBLE_WRITES) begin
                // three 0x3 wake-up nibbles with long holds, then 0x2
                nib = (r_idx[2:1] == 2'd3) ? 4'h2 : 4'h3;
                wr.hold_ms = (r_idx[0] && r_idx[2:1] != 2'd3) ? 3'd6 : 3'd1;
            end else begin
                lbyte = init_byte(j[3:2]);
                ext   = (j[3:2] == 2'd3) ? 2'd2 : 2'd1;
                nib   = r_idx[1] ? lbyte[3:0] : lbyte[7:4];
                wr.hold_ms = low_end ? 3'd1 + {1'b0, ext} : 3'd1;
            end
            wr.last_write = (r_idx == INIT_WRITES - 5'd1);
        end else begin
            lbyte = r_idx[2] ? i_job.b1 : i_job.b0;
            rs    = r_idx[2] ? 1'b0 : i_job.rs0;
            ext   = r_idx[2] ? 2'd1 : i_job.x0;
            nib   = r_idx[1] ? lbyte[3:0] : lbyte[7:4];
            wr.hold_ms    = low_end ? 3'd1 + {1'b0, ext} : 3'd1;
            wr.last_write = (r_idx == (i_job.two ? 5'd7 : 5'd3));
        end
        wr.expander_byte = {nib, 4'h0}
                         | (8'(i_backlight) << BL_BIT_POS)
                         | (8'(rs) << RS_BIT_POS)
                         | (8'(1'b0) << RW_BIT_POS)
                         | (8'(en) << EN_BIT_POS);
    end

    assign o_job_pop = emit && wr.last_write;
    assign o_wr      = r_wr;
    assign o_valid   = r_valid;

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_wr <= wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 5'd0;
            r_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_idx <= wr.last_write ? 5'd0 : r_idx + 5'd1;
            end
            if (slot_free) begin
                r_valid <= emit;
            end
        end
    end

endmodule

### src/char_lcd_i2c_nibble_sequencer_top.sv
// Top level of the HD44780 4-bit LCD sequencer over an I2C expander.
// Depends on lcdseq_pkg, lcdseq_front, lcdseq_jobq, lcdseq_back.

// Commands enter through a queue-style port and are turned at once into jobs
// in a two-entry queue; the write sequencer emits one expander write per clock
// while the result register is free. A character makes 4 expander writes (8
// when it wraps the line), set position, newline, clear and return home 4, init
// 24, and a carriage return or an unknown kind none. Commands are accepted while
// fewer than two jobs wait, so a new one can enter while earlier writes are still
// going out; with both job entries taken every command, even one that makes no
// writes, waits for the head job to finish. Registers: display_columns at 0x0,
// display_rows at 0x4, backlight at 0x8.
module char_lcd_i2c_nibble_sequencer_top import lcdseq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  t_cmd        i_cmd,
    output logic        empty,
    input  logic        pop,
    output t_wr         o_wr,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [5:0] r_columns;
    logic [2:0] r_rows;
    logic       r_backlight;
    logic       cfg_wr;
    logic       accept;
    logic       job_push, job_pop;
    t_job       front_job, head_job;
    t_q_stat    qstat;
    logic       out_valid;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns   <= 6'd16;
            r_rows      <= 3'd2;
            r_backlight <= 1'b1;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_COLUMNS:   r_columns   <= pwdata[5:0];
                REG_ROWS:      r_rows      <= pwdata[2:0];
                REG_BACKLIGHT: r_backlight <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_COLUMNS:   prdata = {26'd0, r_columns};
            REG_ROWS:      prdata = {29'd0, r_rows};
            REG_BACKLIGHT: prdata = {31'd0, r_backlight};
            default:       prdata = 32'd0;
        endcase
    end

    assign full   = qstat.full;
    assign accept = push && !qstat.full;
    assign empty  = !out_valid;

    lcdseq_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_cmd      (i_cmd),
        .i_columns  (r_columns),
        .i_rows     (r_rows),
        .o_job_push (job_push),
        .o_job      (front_job)
    );

    lcdseq_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (front_job),
        .i_pop   (job_pop),
        .o_job   (head_job),
        .o_stat  (qstat)
    );

    lcdseq_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (head_job),
        .i_qstat     (qstat),
        .i_backlight (r_backlight),
        .i_pop       (pop),
        .o_job_pop   (job_pop),
        .o_wr        (o_wr),
        .o_valid     (out_valid)
    );

endmodule

### test/lcdseq_write_checker.sv
// Checker for the LCD nibble sequencer: watches the command, write and APB channels,
// predicts every expander write and compares it with what the block pops.
// Depends on lcdseq_pkg for the payload structs, command codes and bit positions.
`timescale 1ns / 1ps

module lcdseq_write_checker import lcdseq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_full,
    input  t_cmd        i_cmd,
    input  logic        i_empty,
    input  logic        i_pop,
    input  t_wr         i_wr,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_fail_count,
    output int          o_outstanding,
    output int          o_checked
);

    localparam logic [7:0] FUNCTION_SET_BYTE = 8'h2c;
    localparam logic [7:0] DISPLAY_ON_BYTE   = 8'h0d;
    localparam logic [7:0] ENTRY_MODE_BYTE   = 8'h06;
    localparam logic [3:0] WAKE_NIBBLE       = 4'h3;
    localparam logic [3:0] FOUR_BIT_NIBBLE   = 4'h2;

    logic [7:0] ddram_row_start [4] = '{8'h00, 8'h40, 8'h14, 8'h54};

    logic [5:0] cfg_columns;
    logic [2:0] cfg_rows;
    logic       cfg_backlight;
    logic [5:0] cursor_col;
    logic [1:0] cursor_row;

    t_wr lcd_writes_due[$];
    int  fail_count;
    int  checked;

    function automatic void add_write(input logic [3:0] nib, input logic rs, input logic en,
                                      input logic [2:0] hold);
        t_wr w;
        w = '0;
        w.expander_byte = {nib, 4'b0000};
        w.expander_byte[BL_BIT_POS] = cfg_backlight;
        w.expander_byte[RS_BIT_POS] = rs;
        w.expander_byte[EN_BIT_POS] = en;
        w.hold_ms = hold;
        lcd_writes_due.push_back(w);
    endfunction

    // Strobe a nibble: enable high, then enable low with the extra settle time.
    function automatic void add_nibble(input logic [3:0] nib, input logic rs,
                                       input logic [2:0] extra_ms);
        add_write(nib, rs, 1'b1, 3'd1);
        add_write(nib, rs, 1'b0, 3'd1 + extra_ms);
    endfunction

    function automatic void add_lcd_byte(input logic [7:0] data, input logic rs,
                                         input logic [2:0] extra_ms);
        add_nibble(data[7:4], rs, 3'd0);
        add_nibble(data[3:0], rs, extra_ms);
    endfunction

    function automatic void move_cursor(input logic [5:0] col, input logic [1:0] row);
        logic [7:0] addr;
        addr = CMD_SET_DDRAM + ddram_row_start[row] + {2'b00, col};
        add_lcd_byte(addr, 1'b0, 3'd1);
        cursor_col = col;
        cursor_row = row;
    endfunction

    function automatic void start_next_line();
        int rows;
        rows = (cfg_rows == 3'd0) ? 1 : (cfg_rows > 3'd4) ? 4 : int'(cfg_rows);
        move_cursor(6'd0, 2'((int'(cursor_row) + 1) % rows));
    endfunction

    function automatic void sequence_writes(input t_cmd c);
        int first;
        int nx;
        first = lcd_writes_due.size();
        case (c.kind)
            KIND_PUT: begin
                if (c.character == CHAR_CR) begin
                    cursor_col = 6'd0;
                end else if (c.character == CHAR_LF) begin
                    start_next_line();
                end else begin
                    add_lcd_byte(c.character, 1'b1, 3'd1);
                    // compare the unmasked column so a stored column past the limit wraps
                    nx = int'(cursor_col) + 1;
                    cursor_col = nx[5:0];
                    if (nx >= int'(cfg_columns)) start_next_line();
                end
            end
            KIND_SETPOS: move_cursor(c.target_column, c.target_row);
            KIND_CLEAR, KIND_HOME: begin
                add_lcd_byte((c.kind == KIND_CLEAR) ? CMD_CLEAR : CMD_HOME, 1'b0, 3'd2);
                cursor_col = 6'd0;
                cursor_row = 2'd0;
            end
            KIND_INIT: begin
                repeat (3) add_nibble(WAKE_NIBBLE, 1'b0, 3'd5);
                add_nibble(FOUR_BIT_NIBBLE, 1'b0, 3'd0);
                add_lcd_byte(FUNCTION_SET_BYTE, 1'b0, 3'd1);
                add_lcd_byte(DISPLAY_ON_BYTE, 1'b0, 3'd1);
                add_lcd_byte(ENTRY_MODE_BYTE, 1'b0, 3'd1);
                add_lcd_byte(CMD_CLEAR, 1'b0, 3'd2);
                cursor_col = 6'd0;
                cursor_row = 2'd0;
            end
            default: ;
        endcase
        if (lcd_writes_due.size() > first)
            lcd_writes_due[lcd_writes_due.size() - 1].last_write = 1'b1;
    endfunction

    always @(posedge i_clk) begin
        t_wr want;
        if (!i_rst_n) begin
            cfg_columns   = 6'd16;
            cfg_rows      = 3'd2;
            cfg_backlight = 1'b1;
            cursor_col    = 6'd0;
            cursor_row    = 2'd0;
            lcd_writes_due.delete();
            fail_count    = 0;
            checked       = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    REG_COLUMNS:   cfg_columns   = i_pwdata[5:0];
                    REG_ROWS:      cfg_rows      = i_pwdata[2:0];
                    REG_BACKLIGHT: cfg_backlight = i_pwdata[0];
                    default: ;
                endcase
            end
            // check the popped write before predicting the newly accepted command
            if (i_pop && !i_empty) begin
                if (lcd_writes_due.size() == 0) begin
                    $error("unexpected write: byte %h hold %0d last %0b",
                           i_wr.expander_byte, i_wr.hold_ms, i_wr.last_write);
                    fail_count++;
                end else begin
                    want = lcd_writes_due.pop_front();
                    checked++;
                    if (i_wr.expander_byte !== want.expander_byte) begin
                        $error("expander_byte: expected %h, got %h",
                               want.expander_byte, i_wr.expander_byte);
                        fail_count++;
                    end
                    if (i_wr.hold_ms !== want.hold_ms) begin
                        $error("hold_ms: expected %0d, got %0d", want.hold_ms, i_wr.hold_ms);
                        fail_count++;
                    end
                    if (i_wr.last_write !== want.last_write) begin
                        $error("last_write: expected %0b, got %0b",
                               want.last_write, i_wr.last_write);
                        fail_count++;
                    end
                end
            end
            if (i_push && !i_full) sequence_writes(i_cmd);
        end
        o_fail_count  <= fail_count;
        o_outstanding <= lcd_writes_due.size();
        o_checked     <= checked;
    end

endmodule

### test/char_lcd_i2c_nibble_sequencer_top_test.sv
// Testbench top for the LCD nibble sequencer: clock, reset, APB setup, command
// stimulus and the verdict. Depends on lcdseq_pkg, the block and lcdseq_write_checker.
`timescale 1ns / 1ps

module char_lcd_i2c_nibble_sequencer_top_test;
    import lcdseq_pkg::*;

    localparam int N_SETTINGS    = 8;
    localparam int ITEMS_PER_SET = 42;
    localparam int DRAIN_CYCLES  = 40;

    int columns_set [N_SETTINGS] = '{16, 40, 1, 20, 0, 63, 8, 5};
    int rows_set    [N_SETTINGS] = '{2, 4, 1, 4, 0, 7, 3, 1};
    int light_set   [N_SETTINGS] = '{1, 0, 1, 1, 0, 1, 0, 1};

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        push     = 1'b0;
    t_cmd        cmd      = '0;
    logic        pop      = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic        full;
    logic        empty;
    t_wr         wr;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int outstanding;
    int checked;
    int burst_left = 0;
    int commands_sent = 0;

    char_lcd_i2c_nibble_sequencer_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_cmd   (cmd),
        .empty   (empty),
        .pop     (pop),
        .o_wr    (wr),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    lcdseq_write_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_full        (full),
        .i_cmd         (cmd),
        .i_empty       (empty),
        .i_pop         (pop),
        .i_wr          (wr),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding),
        .o_checked     (checked)
    );

    always #5 i_clk = ~i_clk;

    // Receiver: at each wrap of pop_phase, pick anew between free-running, coin-flip and sparse pops.
    int pop_mode = 0;
    int pop_phase = 0;
    always @(posedge i_clk) begin
        if (pop_phase == 0) pop_mode <= $urandom_range(0, 2);
        pop_phase <= (pop_phase == 49) ? 0 : pop_phase + 1;
        case (pop_mode)
            0:       pop <= 1'b1;
            1:       pop <= $urandom_range(0, 1);
            default: pop <= ($urandom_range(0, 4) == 0);
        endcase
    end

    task automatic write_register(input logic [1:0] index, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Hold push high across a burst; drop it only when a gap starts.
    task automatic send_command(input t_cmd c);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 4);
            if (gap != 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        cmd  <= c;
        push <= 1'b1;
        do @(posedge i_clk); while (full);
        commands_sent++;
    endtask

    // Drain all predicted writes, then give silent commands time to settle.
    task automatic wait_idle();
        push <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_cmd make_command(input logic [2:0] kind, input logic [7:0] ch,
                                          input logic [5:0] col, input logic [1:0] row);
        t_cmd c;
        c.kind = kind;
        c.character = ch;
        c.target_column = col;
        c.target_row = row;
        return c;
    endfunction

    function automatic t_cmd random_command();
        t_cmd c;
        int pick;
        c = make_command(KIND_PUT, 8'($urandom), 6'($urandom), 2'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 50)      c.kind = KIND_PUT;
        else if (pick < 56) c.character = CHAR_CR;
        else if (pick < 62) c.character = CHAR_LF;
        else if (pick < 77) c.kind = KIND_SETPOS;
        else if (pick < 83) c.kind = KIND_CLEAR;
        else if (pick < 88) c.kind = KIND_HOME;
        else if (pick < 93) c.kind = KIND_INIT;
        else                c.kind = 3'($urandom_range(5, 7));
        return c;
    endfunction

    initial begin
        t_cmd c;
        int counted;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_register(REG_COLUMNS, 16);
        write_register(REG_ROWS, 2);
        write_register(REG_BACKLIGHT, 1);

        send_command(make_command(KIND_INIT, 8'h00, 6'd0, 2'd0));
        send_command(make_command(KIND_PUT, 8'h41, 6'd0, 2'd0));
        send_command(make_command(KIND_PUT, 8'h00, 6'd63, 2'd3));
        send_command(make_command(KIND_PUT, 8'hff, 6'd0, 2'd0));
        send_command(make_command(KIND_PUT, CHAR_CR, 6'd0, 2'd0));
        send_command(make_command(KIND_PUT, CHAR_LF, 6'd0, 2'd0));
        send_command(make_command(KIND_PUT, CHAR_LF, 6'd0, 2'd0));
        send_command(make_command(KIND_SETPOS, 8'h00, 6'd15, 2'd1));
        send_command(make_command(KIND_PUT, 8'h78, 6'd0, 2'd0));
        send_command(make_command(KIND_SETPOS, 8'hff, 6'd39, 2'd3));
        send_command(make_command(KIND_SETPOS, 8'h00, 6'd63, 2'd3));
        send_command(make_command(KIND_PUT, 8'h7e, 6'd0, 2'd0));
        send_command(make_command(KIND_SETPOS, 8'h00, 6'd0, 2'd0));
        send_command(make_command(KIND_CLEAR, 8'hff, 6'd63, 2'd3));
        send_command(make_command(KIND_HOME, 8'h00, 6'd0, 2'd0));
        send_command(make_command(3'd5, 8'h41, 6'd1, 2'd1));
        send_command(make_command(3'd7, 8'hff, 6'd63, 2'd3));
        send_command(make_command(KIND_SETPOS, 8'h00, 6'd5, 2'd2));
        send_command(make_command(KIND_PUT, CHAR_CR, 6'd0, 2'd0));
        send_command(make_command(KIND_INIT, 8'hff, 6'd63, 2'd3));
        wait_idle();

        for (int s = 0; s < N_SETTINGS; s++) begin
            write_register(REG_COLUMNS, columns_set[s]);
            write_register(REG_ROWS, rows_set[s]);
            write_register(REG_BACKLIGHT, light_set[s]);
            counted = 0;
            while (counted < ITEMS_PER_SET) begin
                c = random_command();
                send_command(c);
                if (c.kind <= KIND_INIT) counted++;
            end
            wait_idle();
        end

        $display("Sent %0d commands across %0d display settings; %0d expander writes checked.",
                 commands_sent, N_SETTINGS + 1, checked);
        if (fail_count == 0 && outstanding == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
